// File: rtl/assert_macros.svh
// Assertion macros shared by the thermistor unit RTL.
// Needs nothing else; files that assert include it by bare name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is asserted.
`define NTC_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define NTC_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/ntc_pkg.sv
// Shared types, constants and the resistance table for the thermistor unit.
// Depends on nothing; used by every module in the folder.
package ntc_pkg;

	localparam int SAMPLES_DEF       = 10;
	localparam int TABLE_ENTRIES_DEF = 61;
	localparam int ROM_LEN           = 61;
	localparam int IDX_W             = 6;
	localparam int COLD_DEG          = -10;

	localparam int VOLT_W = 12;
	localparam int SER_W  = 20;
	localparam int SUM_W  = 16;
	localparam int CNT_W  = 4;
	localparam int TEMP_W = 15;
	localparam int RES_W  = 32;
	localparam int STAT_W = 2;
	localparam int OHM_W  = 16;

	localparam int SERIES_RST = 10000;
	localparam int FULL_RST   = 3300;

	// divider geometry: numerator left aligned, one quotient bit a cycle
	localparam int NUM_W     = 32;
	localparam int DEN_W     = 12;
	localparam int ITER_W    = 6;
	localparam int FRAC_W    = 20;
	localparam int ITER_RES  = NUM_W;
	localparam int ITER_FRAC = FRAC_W;

	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_AW    = 1;
	localparam int FIFO_CW    = 2;

	localparam logic [STAT_W-1:0] ST_TABLE = 2'd0;
	localparam logic [STAT_W-1:0] ST_COLD  = 2'd1;
	localparam logic [STAT_W-1:0] ST_HOT   = 2'd2;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

	localparam logic [0:0] REG_SERIES = 1'b0;
	localparam logic [0:0] REG_FULL   = 1'b1;

	typedef struct packed {
		logic              start;
		logic [NUM_W-1:0]  num;
		logic [DEN_W-1:0]  den;
		logic [ITER_W-1:0] iters;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [NUM_W-1:0] quot;
	} div_rsp_t;

	// thermistor ohms per whole degree, -10 C upwards, descending
	function automatic logic [OHM_W-1:0] rom_ohms(input logic [IDX_W-1:0] idx);
		logic [OHM_W-1:0] r;
		case (idx)
			6'd0:  r = 16'd51815;
			6'd1:  r = 16'd49283;
			6'd2:  r = 16'd46889;
			6'd3:  r = 16'd44624;
			6'd4:  r = 16'd42481;
			6'd5:  r = 16'd40450;
			6'd6:  r = 16'd38526;
			6'd7:  r = 16'd36702;
			6'd8:  r = 16'd34971;
			6'd9:  r = 16'd33329;
			6'd10: r = 16'd31770;
			6'd11: r = 16'd30253;
			6'd12: r = 16'd28815;
			6'd13: r = 16'd27453;
			6'd14: r = 16'd26160;
			6'd15: r = 16'd24935;
			6'd16: r = 16'd23772;
			6'd17: r = 16'd22668;
			6'd18: r = 16'd21620;
			6'd19: r = 16'd20626;
			6'd20: r = 16'd19681;
			6'd21: r = 16'd18784;
			6'd22: r = 16'd17932;
			6'd23: r = 16'd17122;
			6'd24: r = 16'd16353;
			6'd25: r = 16'd15621;
			6'd26: r = 16'd14925;
			6'd27: r = 16'd14263;
			6'd28: r = 16'd13634;
			6'd29: r = 16'd13035;
			6'd30: r = 16'd12465;
			6'd31: r = 16'd11922;
			6'd32: r = 16'd11406;
			6'd33: r = 16'd10914;
			6'd34: r = 16'd10446;
			6'd35: r = 16'd10000;
			6'd36: r = 16'd9574;
			6'd37: r = 16'd9169;
			6'd38: r = 16'd8783;
			6'd39: r = 16'd8415;
			6'd40: r = 16'd8064;
			6'd41: r = 16'd7729;
			6'd42: r = 16'd7410;
			6'd43: r = 16'd7105;
			6'd44: r = 16'd6814;
			6'd45: r = 16'd6537;
			6'd46: r = 16'd6272;
			6'd47: r = 16'd6019;
			6'd48: r = 16'd5778;
			6'd49: r = 16'd5547;
			6'd50: r = 16'd5327;
			6'd51: r = 16'd5116;
			6'd52: r = 16'd4915;
			6'd53: r = 16'd4722;
			6'd54: r = 16'd4539;
			6'd55: r = 16'd4363;
			6'd56: r = 16'd4195;
			6'd57: r = 16'd4034;
			6'd58: r = 16'd3880;
			6'd59: r = 16'd3733;
			6'd60: r = 16'd3592;
			default: r = 16'd0;
		endcase
		return r;
	endfunction

	// Q8 temperature of a table entry
	function automatic logic signed [TEMP_W-1:0] deg_q8(input logic [IDX_W-1:0] idx);
		logic signed [TEMP_W-1:0] d;
		d = $signed({{(TEMP_W-IDX_W){1'b0}}, idx}) + $signed(TEMP_W'(COLD_DEG));
		return d <<< 8;
	endfunction

endpackage

// File: rtl/ntc_fifo.sv
// Two-entry queue of sample sums between the front and back parts.
// Depends on ntc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ntc_fifo (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	input  logic [ntc_pkg::SUM_W-1:0] push_data,
	input  logic                     pop,
	output logic [ntc_pkg::SUM_W-1:0] head,
	output logic                     full,
	output logic                     empty
);

	logic [ntc_pkg::SUM_W-1:0]   mem_q [ntc_pkg::FIFO_DEPTH];
	logic [ntc_pkg::FIFO_AW-1:0] wr_q;
	logic [ntc_pkg::FIFO_AW-1:0] rd_q;
	logic [ntc_pkg::FIFO_CW-1:0] count_q;

	assign full  = (count_q == ntc_pkg::FIFO_CW'(ntc_pkg::FIFO_DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	`NTC_ASSERT(a_no_overflow, clk, arst_n, push |-> !full, "word pushed into full queue")
	`NTC_ASSERT(a_no_underflow, clk, arst_n, pop |-> !empty, "word popped from empty queue")
	`NTC_ASSERT(a_count_bound, clk, arst_n, count_q <= ntc_pkg::FIFO_CW'(ntc_pkg::FIFO_DEPTH), "queue count past depth")

endmodule

// File: rtl/ntc_front.sv
// Front part: takes sample words, accumulates them and queues each sum.
// Depends on ntc_pkg.
module ntc_front #(
	parameter int SAMPLES_PER_RESULT = ntc_pkg::SAMPLES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [ntc_pkg::VOLT_W-1:0] voltage_mv,
	input  logic                      q_full,
	output logic                      q_push,
	output logic [ntc_pkg::SUM_W-1:0]  q_data
);

	logic [ntc_pkg::SUM_W-1:0] sum_q;
	logic [ntc_pkg::CNT_W-1:0] count_q;
	logic [ntc_pkg::SUM_W-1:0] sum_nx;
	logic                      take;
	logic                      last;

	assign in_ready = !q_full;
	assign take     = in_valid && in_ready;
	assign sum_nx   = sum_q + ntc_pkg::SUM_W'(voltage_mv);
	assign last     = ({1'b0, count_q} + 1'b1) >= (ntc_pkg::CNT_W + 1)'(SAMPLES_PER_RESULT);
	assign q_push   = take && last;
	assign q_data   = sum_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			count_q <= '0;
		end else if (take) begin
			// restart the window once the sum is queued
			if (last) begin
				sum_q   <= '0;
				count_q <= '0;
			end else begin
				sum_q   <= sum_nx;
				count_q <= count_q + 1'b1;
			end
		end
	end

endmodule

// File: rtl/ntc_div.sv
// Restoring divider, one quotient bit a cycle, shared by the back part.
// Depends on ntc_pkg (request and response structs).
module ntc_div (
	input  logic              clk,
	input  logic              arst_n,
	input  ntc_pkg::div_req_t req,
	output ntc_pkg::div_rsp_t rsp
);

	logic [ntc_pkg::NUM_W-1:0]  num_q;
	logic [ntc_pkg::NUM_W-1:0]  quot_q;
	logic [ntc_pkg::DEN_W-1:0]  den_q;
	logic [ntc_pkg::DEN_W-1:0]  rem_q;
	logic [ntc_pkg::ITER_W-1:0] cnt_q;
	logic                       busy_q;
	logic                       done_q;
	logic [ntc_pkg::DEN_W:0]    rem_sh;
	logic [ntc_pkg::DEN_W:0]    rem_sub;
	logic                       ge;

	assign rem_sh  = {rem_q, num_q[ntc_pkg::NUM_W-1]};
	assign ge      = rem_sh >= {1'b0, den_q};
	assign rem_sub = rem_sh - {1'b0, den_q};

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q  <= req.num;
			den_q  <= req.den;
			rem_q  <= '0;
			quot_q <= '0;
		end else if (busy_q) begin
			num_q  <= {num_q[ntc_pkg::NUM_W-2:0], 1'b0};
			rem_q  <= ge ? rem_sub[ntc_pkg::DEN_W-1:0] : rem_sh[ntc_pkg::DEN_W-1:0];
			quot_q <= {quot_q[ntc_pkg::NUM_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.iters;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == ntc_pkg::ITER_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

// File: rtl/ntc_back.sv
// Back part: mean, divider resistance, table search and interpolation.
// Depends on ntc_pkg, ntc_div and assert_macros.svh.
`include "assert_macros.svh"

module ntc_back #(
	parameter int SAMPLES_PER_RESULT = ntc_pkg::SAMPLES_DEF,
	parameter int TABLE_ENTRIES      = ntc_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [ntc_pkg::SER_W-1:0]          series_resistance,
	input  logic [ntc_pkg::VOLT_W-1:0]         full_scale_mv,
	input  logic                              q_empty,
	input  logic [ntc_pkg::SUM_W-1:0]          q_head,
	output logic                              q_pop,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [ntc_pkg::TEMP_W-1:0]  temperature_q8,
	output logic [ntc_pkg::VOLT_W-1:0]         mean_voltage_mv,
	output logic [ntc_pkg::RES_W-1:0]          resistance_ohms,
	output logic [ntc_pkg::STAT_W-1:0]         status
);

	localparam int N_CLIP  = (TABLE_ENTRIES > ntc_pkg::ROM_LEN) ? ntc_pkg::ROM_LEN : TABLE_ENTRIES;
	localparam int N_USED  = (N_CLIP < 2) ? 2 : N_CLIP;
	localparam logic [ntc_pkg::IDX_W-1:0] LAST_IDX = ntc_pkg::IDX_W'(N_USED - 1);

	// sum / SAMPLES_PER_RESULT as (sum * MEAN_MUL) >> MEAN_SH, exact for every sum
	localparam int MEAN_SH = ntc_pkg::SUM_W + $clog2(SAMPLES_PER_RESULT);
	localparam logic [ntc_pkg::SUM_W:0] MEAN_MUL = (ntc_pkg::SUM_W + 1)'(
		((64'd1 << MEAN_SH) + 64'(SAMPLES_PER_RESULT) - 64'd1) / 64'(SAMPLES_PER_RESULT));

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_CMP    = 4'd2;
	localparam logic [3:0] S_RSTART = 4'd3;
	localparam logic [3:0] S_RES    = 4'd4;
	localparam logic [3:0] S_CHK    = 4'd5;
	localparam logic [3:0] S_SRCH   = 4'd6;
	localparam logic [3:0] S_FRAC   = 4'd7;
	localparam logic [3:0] S_WRITE  = 4'd8;

	logic [3:0]                       state_q;
	logic [ntc_pkg::VOLT_W-1:0]        mean_q;
	logic [ntc_pkg::RES_W-1:0]         prod_q;
	logic [ntc_pkg::RES_W-1:0]         res_q;
	logic [ntc_pkg::IDX_W-1:0]         lo_q;
	logic [ntc_pkg::IDX_W-1:0]         hi_q;
	logic signed [ntc_pkg::TEMP_W-1:0] t_q;
	logic signed [ntc_pkg::TEMP_W-1:0] last_q;
	logic [ntc_pkg::STAT_W-1:0]        stat_q;
	logic                             out_valid_q;

	ntc_pkg::div_req_t div_req;
	ntc_pkg::div_rsp_t div_rsp;

	logic [2*ntc_pkg::SUM_W:0] mean_prod;
	logic [ntc_pkg::IDX_W:0]   mid_sum;
	logic [ntc_pkg::IDX_W-1:0] mid;
	logic [ntc_pkg::OHM_W-1:0] r_mid;
	logic [ntc_pkg::OHM_W-1:0] r_lo;
	logic [ntc_pkg::OHM_W-1:0] r_hi;
	logic [ntc_pkg::OHM_W-1:0] r_first;
	logic [ntc_pkg::OHM_W-1:0] r_last;
	logic [ntc_pkg::OHM_W-1:0] seg_d;
	logic [ntc_pkg::OHM_W-1:0] seg_off;
	logic [ntc_pkg::FRAC_W-1:0] frac_num;
	logic                      narrow;
	logic                      slot_free;

	assign mean_prod = (2*ntc_pkg::SUM_W + 1)'(q_head) * (2*ntc_pkg::SUM_W + 1)'(MEAN_MUL);
	assign mid_sum   = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid       = mid_sum[ntc_pkg::IDX_W:1];
	assign r_mid     = ntc_pkg::rom_ohms(mid);
	assign r_lo      = ntc_pkg::rom_ohms(lo_q);
	assign r_hi      = ntc_pkg::rom_ohms(hi_q);
	assign r_first   = ntc_pkg::rom_ohms('0);
	assign r_last    = ntc_pkg::rom_ohms(LAST_IDX);
	assign narrow    = (hi_q - lo_q) <= ntc_pkg::IDX_W'(1);
	// segment width and offset span at most one table step, so 12 bits suffice
	assign seg_d     = r_lo - r_hi;
	assign seg_off   = r_lo - res_q[ntc_pkg::OHM_W-1:0];
	assign frac_num  = {seg_off[ntc_pkg::DEN_W-1:0], 8'd0}
		+ ntc_pkg::FRAC_W'(seg_d[ntc_pkg::DEN_W-1:1]);
	assign slot_free = !out_valid_q || out_ready;

	assign q_pop = (state_q == S_IDLE) && !q_empty;

	always_comb begin
		div_req.start = 1'b0;
		div_req.num   = '0;
		div_req.den   = '0;
		div_req.iters = '0;
		case (state_q)
			S_RSTART: begin
				div_req.start = 1'b1;
				div_req.num   = prod_q;
				div_req.den   = full_scale_mv - mean_q;
				div_req.iters = ntc_pkg::ITER_W'(ntc_pkg::ITER_RES);
			end
			S_SRCH: begin
				div_req.start = narrow;
				div_req.num   = {frac_num, {(ntc_pkg::NUM_W-ntc_pkg::FRAC_W){1'b0}}};
				div_req.den   = seg_d[ntc_pkg::DEN_W-1:0];
				div_req.iters = ntc_pkg::ITER_W'(ntc_pkg::ITER_FRAC);
			end
			default: begin
				div_req.start = 1'b0;
			end
		endcase
	end

	ntc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (!q_empty) begin
					mean_q <= mean_prod[MEAN_SH +: ntc_pkg::VOLT_W];
				end
			end
			S_CMP: begin
				prod_q <= ntc_pkg::RES_W'(mean_q) * ntc_pkg::RES_W'(series_resistance);
				if (mean_q >= full_scale_mv) begin
					stat_q <= ntc_pkg::ST_RANGE;
					t_q    <= last_q;
					res_q  <= '0;
				end
			end
			S_RES: begin
				if (div_rsp.done) begin
					res_q <= div_rsp.quot;
				end
			end
			S_CHK: begin
				lo_q <= '0;
				hi_q <= LAST_IDX;
				if (res_q > ntc_pkg::RES_W'(r_first)) begin
					stat_q <= ntc_pkg::ST_COLD;
					t_q    <= ntc_pkg::deg_q8('0);
				end else if (res_q < ntc_pkg::RES_W'(r_last)) begin
					stat_q <= ntc_pkg::ST_HOT;
					t_q    <= ntc_pkg::deg_q8(LAST_IDX);
				end else if (res_q == ntc_pkg::RES_W'(r_last)) begin
					stat_q <= ntc_pkg::ST_TABLE;
					t_q    <= ntc_pkg::deg_q8(LAST_IDX);
				end
			end
			S_SRCH: begin
				if (!narrow) begin
					if (ntc_pkg::RES_W'(r_mid) >= res_q) begin
						lo_q <= mid;
					end else begin
						hi_q <= mid;
					end
				end
			end
			S_FRAC: begin
				if (div_rsp.done) begin
					stat_q <= ntc_pkg::ST_TABLE;
					t_q    <= ntc_pkg::deg_q8(lo_q)
						+ $signed({{(ntc_pkg::TEMP_W-9){1'b0}}, div_rsp.quot[8:0]});
				end
			end
			default: begin
				prod_q <= prod_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (!q_empty) begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					state_q <= (mean_q >= full_scale_mv) ? S_WRITE : S_RSTART;
				end
				S_RSTART: begin
					state_q <= S_RES;
				end
				S_RES: begin
					if (div_rsp.done) begin
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					if (res_q > ntc_pkg::RES_W'(r_first) || res_q <= ntc_pkg::RES_W'(r_last)) begin
						state_q <= S_WRITE;
					end else begin
						state_q <= S_SRCH;
					end
				end
				S_SRCH: begin
					if (narrow) begin
						state_q <= S_FRAC;
					end
				end
				S_FRAC: begin
					if (div_rsp.done) begin
						state_q <= S_WRITE;
					end
				end
				S_WRITE: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// hold the last table temperature for out-of-range results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
		end else if (state_q == S_WRITE && slot_free && stat_q != ntc_pkg::ST_RANGE) begin
			last_q <= t_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_WRITE && slot_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_WRITE && slot_free) begin
			temperature_q8  <= t_q;
			mean_voltage_mv <= mean_q;
			resistance_ohms <= res_q;
			status          <= stat_q;
		end
	end

	assign out_valid = out_valid_q;

	`NTC_ASSERT(a_div_start_idle, clk, arst_n, div_req.start |-> !div_rsp.busy, "divider restarted while busy")
	`NTC_ASSERT(a_search_order, clk, arst_n, (state_q == S_SRCH) |-> (lo_q < hi_q), "search bracket collapsed")
	`NTC_ASSERT(a_range_res_zero, clk, arst_n, (out_valid && status == ntc_pkg::ST_RANGE) |-> (resistance_ohms == '0), "out-of-range word carries resistance")

endmodule

// File: rtl/ntc_thermistor_temperature_unit.sv
// NTC thermistor temperature unit.
// Input channel in_valid/in_ready carries one voltage_mv word per sample.
// After every SAMPLES_PER_RESULT samples one result word leaves on
// out_valid/out_ready: temperature_q8, mean_voltage_mv, resistance_ohms, status.
// The front accumulates samples and queues each window sum (two entries);
// the back takes a sum, scales it to the mean with a reciprocal multiply,
// forms mean*series/(full-mean), searches the table and interpolates the fraction.
// Both divisions share one divider that yields a bit a cycle. With the back
// idle, the result of a window passes the mean, the resistance division, the
// range check and search, the fraction division and the load of the output
// register, in that order. Clamped results skip the search and the fraction;
// out-of-range ones skip both divisions and the search.
// The back takes one queued sum at a time and pops the next only when idle;
// samples are taken one a cycle while the queue has room.
// A stalled receiver holds the result in the output register; the back then
// waits with its next result, and the front stops once the queue is full.
// Reset clears the window, the held temperature and the registers to 10000
// ohms and 3300 mV. APB: series_resistance at 0x0, full_scale_mv at 0x4.
module ntc_thermistor_temperature_unit #(
	parameter int SAMPLES_PER_RESULT = ntc_pkg::SAMPLES_DEF,
	parameter int TABLE_ENTRIES      = ntc_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [2:0]                        paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [ntc_pkg::VOLT_W-1:0]         voltage_mv,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [ntc_pkg::TEMP_W-1:0]  temperature_q8,
	output logic [ntc_pkg::VOLT_W-1:0]         mean_voltage_mv,
	output logic [ntc_pkg::RES_W-1:0]          resistance_ohms,
	output logic [ntc_pkg::STAT_W-1:0]         status
);

	logic [ntc_pkg::SER_W-1:0]  series_q;
	logic [ntc_pkg::VOLT_W-1:0] full_q;
	logic                       wr_en;
	logic                       q_push;
	logic                       q_pop;
	logic                       q_full;
	logic                       q_empty;
	logic [ntc_pkg::SUM_W-1:0]  q_data;
	logic [ntc_pkg::SUM_W-1:0]  q_head;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			series_q <= ntc_pkg::SER_W'(ntc_pkg::SERIES_RST);
			full_q   <= ntc_pkg::VOLT_W'(ntc_pkg::FULL_RST);
		end else if (wr_en) begin
			case (paddr[2])
				ntc_pkg::REG_SERIES: series_q <= pwdata[ntc_pkg::SER_W-1:0];
				ntc_pkg::REG_FULL:   full_q   <= pwdata[ntc_pkg::VOLT_W-1:0];
				default:             series_q <= series_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			ntc_pkg::REG_SERIES: prdata = {{(32-ntc_pkg::SER_W){1'b0}}, series_q};
			ntc_pkg::REG_FULL:   prdata = {{(32-ntc_pkg::VOLT_W){1'b0}}, full_q};
			default:             prdata = '0;
		endcase
	end

	ntc_front #(
		.SAMPLES_PER_RESULT (SAMPLES_PER_RESULT)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.voltage_mv (voltage_mv),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_data     (q_data)
	);

	ntc_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_data),
		.pop       (q_pop),
		.head      (q_head),
		.full      (q_full),
		.empty     (q_empty)
	);

	ntc_back #(
		.SAMPLES_PER_RESULT (SAMPLES_PER_RESULT),
		.TABLE_ENTRIES      (TABLE_ENTRIES)
	) u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.series_resistance (series_q),
		.full_scale_mv     (full_q),
		.q_empty           (q_empty),
		.q_head            (q_head),
		.q_pop             (q_pop),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.temperature_q8    (temperature_q8),
		.mean_voltage_mv   (mean_voltage_mv),
		.resistance_ohms   (resistance_ohms),
		.status            (status)
	);

endmodule

// File: tb/ntc_result_checker.sv
// Checker for the thermistor unit: follows register writes and sample words,
// predicts each result word and compares it field by field.
// Depends on ntc_pkg for widths, status codes and register indexes.
module ntc_result_checker
	import ntc_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic                     pready,
	input  logic [2:0]               paddr,
	input  logic [31:0]              pwdata,
	input  logic [31:0]              prdata,
	input  logic                     in_valid,
	input  logic                     in_ready,
	input  logic [VOLT_W-1:0]        voltage_mv,
	input  logic                     out_valid,
	input  logic                     out_ready,
	input  logic signed [TEMP_W-1:0] temperature_q8,
	input  logic [VOLT_W-1:0]        mean_voltage_mv,
	input  logic [RES_W-1:0]         resistance_ohms,
	input  logic [STAT_W-1:0]        status,
	output int                       mismatches,
	output int                       outstanding
);

	typedef struct {
		logic signed [TEMP_W-1:0] temp;
		logic [VOLT_W-1:0]        mean;
		logic [RES_W-1:0]         ohms;
		logic [STAT_W-1:0]        stat;
	} reading_t;

	int unsigned ohm_steps [0:ROM_LEN-1] = '{
		51815, 49283, 46889, 44624, 42481, 40450, 38526, 36702, 34971, 33329,
		31770, 30253, 28815, 27453, 26160, 24935, 23772, 22668, 21620, 20626,
		19681, 18784, 17932, 17122, 16353, 15621, 14925, 14263, 13634, 13035,
		12465, 11922, 11406, 10914, 10446, 10000, 9574, 9169, 8783, 8415,
		8064, 7729, 7410, 7105, 6814, 6537, 6272, 6019, 5778, 5547,
		5327, 5116, 4915, 4722, 4539, 4363, 4195, 4034, 3880, 3733,
		3592
	};

	reading_t                 expected_readings [$];
	logic [SER_W-1:0]         series_ohms;
	logic [VOLT_W-1:0]        supply_mv;
	logic [SUM_W-1:0]         window_sum;
	logic [CNT_W-1:0]         window_fill;
	logic signed [15:0]       held_temp;

	function automatic int step_q8(input int idx);
		return (idx + COLD_DEG) * 256;
	endfunction

	// descending table: bracket res between the last entry at or above it and the next
	function automatic void ohms_to_temp(input longint unsigned r,
			output logic signed [15:0] t, output logic [STAT_W-1:0] st);
		int n;
		int lo;
		longint unsigned d;
		longint unsigned num;
		n = (TABLE_ENTRIES_DEF > ROM_LEN) ? ROM_LEN : TABLE_ENTRIES_DEF;
		lo = 0;
		if (r > ohm_steps[0]) begin
			t = 16'(step_q8(0));
			st = ST_COLD;
		end else if (r < ohm_steps[n-1]) begin
			t = 16'(step_q8(n - 1));
			st = ST_HOT;
		end else begin
			for (int i = 0; i < n; i++)
				if (ohm_steps[i] >= r)
					lo = i;
			if (lo == n - 1) begin
				t = 16'(step_q8(lo));
			end else begin
				d = ohm_steps[lo] - ohm_steps[lo+1];
				num = (ohm_steps[lo] - r) * 256;
				t = 16'(step_q8(lo) + int'((num + d / 2) / d));
			end
			st = ST_TABLE;
		end
	endfunction

	task automatic compare_field(input string what, input longint want, input longint got);
		if (want != got) begin
			$display("%0t: %s expected %0d got %0d", $time, what, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		reading_t         r;
		longint unsigned  prod;
		longint unsigned  ohms;
		logic [VOLT_W-1:0] mean;
		if (!arst_n) begin
			series_ohms = SER_W'(SERIES_RST);
			supply_mv = VOLT_W'(FULL_RST);
			window_sum = '0;
			window_fill = '0;
			held_temp = '0;
			expected_readings.delete();
			mismatches = 0;
			outstanding = 0;
		end else begin
			if (psel && penable && pready && pwrite) begin
				if (paddr[2] == REG_SERIES)
					series_ohms = pwdata[SER_W-1:0];
				else
					supply_mv = pwdata[VOLT_W-1:0];
			end
			if (psel && penable && pready && !pwrite) begin
				if (paddr[2] == REG_SERIES)
					compare_field("prdata series", series_ohms, prdata);
				else
					compare_field("prdata full scale", supply_mv, prdata);
			end

			if (in_valid && in_ready) begin
				window_sum = window_sum + voltage_mv;
				if (32'(window_fill) + 1 < SAMPLES_DEF) begin
					window_fill = window_fill + 1'b1;
				end else begin
					mean = VOLT_W'(window_sum / SAMPLES_DEF);
					window_sum = '0;
					window_fill = '0;
					r.mean = mean;
					if (mean >= supply_mv) begin
						// hold the last good temperature
						r.stat = ST_RANGE;
						r.temp = held_temp[TEMP_W-1:0];
						r.ohms = '0;
					end else begin
						prod = mean;
						prod = prod * series_ohms;
						ohms = prod / (supply_mv - mean);
						if (ohms > 64'hFFFF_FFFF)
							ohms = 64'hFFFF_FFFF;
						ohms_to_temp(ohms, held_temp, r.stat);
						r.temp = held_temp[TEMP_W-1:0];
						r.ohms = ohms[RES_W-1:0];
					end
					expected_readings.push_back(r);
				end
			end

			if (out_valid && out_ready) begin
				if (expected_readings.size() == 0) begin
					$display("%0t: result word with none expected: temp %0d mean %0d ohms %0d st %0d",
						$time, temperature_q8, mean_voltage_mv, resistance_ohms, status);
					mismatches++;
				end else begin
					r = expected_readings.pop_front();
					compare_field("temperature_q8", r.temp, temperature_q8);
					compare_field("mean_voltage_mv", r.mean, mean_voltage_mv);
					compare_field("resistance_ohms", r.ohms, resistance_ohms);
					compare_field("status", r.stat, status);
				end
			end
			outstanding = expected_readings.size();
		end
	end

endmodule

// File: tb/tb_top.sv
// Top of the thermistor unit testbench: clock, reset, register writes,
// sample words and result back-pressure; the verdict comes from ntc_result_checker.
// Depends on ntc_pkg and ntc_thermistor_temperature_unit.
module tb_top;
	import ntc_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_AFTER  = 45;
	localparam int HOLD_CYCLES = 600;

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     psel;
	logic                     penable;
	logic                     pwrite;
	logic [2:0]               paddr;
	logic [31:0]              pwdata;
	logic [31:0]              prdata;
	logic                     pready;
	logic                     in_valid;
	logic                     in_ready;
	logic [VOLT_W-1:0]        voltage_mv;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic signed [TEMP_W-1:0] temperature_q8;
	logic [VOLT_W-1:0]        mean_voltage_mv;
	logic [RES_W-1:0]         resistance_ohms;
	logic [STAT_W-1:0]        status;

	int mismatches;
	int outstanding;
	int idle_pct = 0;
	int stall_pct = 0;
	int results_taken = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	int cycle_count = 0;

	ntc_thermistor_temperature_unit u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.voltage_mv      (voltage_mv),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.temperature_q8  (temperature_q8),
		.mean_voltage_mv (mean_voltage_mv),
		.resistance_ohms (resistance_ohms),
		.status          (status)
	);

	ntc_result_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.pready          (pready),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.voltage_mv      (voltage_mv),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.temperature_q8  (temperature_q8),
		.mean_voltage_mv (mean_voltage_mv),
		.resistance_ohms (resistance_ohms),
		.status          (status),
		.mismatches      (mismatches),
		.outstanding     (outstanding)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// result side: random stalls, plus one long hold-off to back the block up
	always @(posedge clk) begin
		if (out_valid && out_ready)
			results_taken <= results_taken + 1;
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else if (!hold_done && results_taken >= HOLD_AFTER) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99, 0) >= stall_pct);
		end
	end

	task automatic write_reg(input logic [0:0] idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic read_reg(input logic [0:0] idx);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_divider(input logic [31:0] series, input logic [31:0] full);
		write_reg(REG_SERIES, series);
		write_reg(REG_FULL, full);
		read_reg(REG_SERIES);
		read_reg(REG_FULL);
	endtask

	// drop valid, wait for every result word, then let the back end go quiet
	task automatic settle();
		in_valid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		repeat (200) @(posedge clk);
	endtask

	task automatic send_sample(input int v);
		while ($urandom_range(99, 0) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		voltage_mv <= VOLT_W'(v);
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
	endtask

	task automatic send_window(input int centre, input int spread);
		int v;
		for (int k = 0; k < SAMPLES_DEF; k++) begin
			v = centre + $urandom_range(2 * spread, 0) - spread;
			if (v < 0)
				v = 0;
			if (v > 4095)
				v = 4095;
			send_sample(v);
		end
	endtask

	task automatic send_noise(input int count);
		for (int k = 0; k < count; k++)
			send_sample($urandom_range(4095, 0));
	endtask

	// aim the window mean at a resistance in or just beyond the table
	task automatic send_targeted(input longint unsigned series, input longint unsigned full);
		longint unsigned target;
		longint unsigned centre;
		target = $urandom_range(56000, 3000);
		centre = target * full / (series + target);
		send_window(int'(centre), $urandom_range(3, 0));
	endtask

	initial begin
		int unsigned series;
		int unsigned full;
		int pick;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		in_valid <= 1'b0;
		voltage_mv <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: out of range before any temperature, exact hit, clamps
		send_window(4095, 0);
		send_window(1650, 0);
		send_window(0, 0);
		send_window(4095, 0);
		send_window(3000, 0);
		settle();
		// resistance equal to the series resistor: first and last table entries
		set_divider(51815, 2000);
		send_window(1000, 0);
		settle();
		set_divider(3592, 2000);
		send_window(1000, 0);
		settle();
		set_divider(10000, 0);
		send_window(0, 0);
		settle();
		set_divider(0, 4095);
		send_window(2000, 0);
		settle();

		for (int seg = 0; seg < 10; seg++) begin
			case (seg % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 88; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 88; end
				default: begin idle_pct = 25; stall_pct = 25; end
			endcase
			case (seg)
				0: begin series = 10000; full = 3300; end
				1: begin series = 20'hFFFFF; full = 4095; end
				2: begin series = 1; full = 1; end
				default: begin
					series = $urandom_range(1000000, 1);
					full = $urandom_range(4095, 1);
				end
			endcase
			set_divider(series, full);
			for (int w = 0; w < 11; w++) begin
				pick = $urandom_range(9, 0);
				if (pick < 7)
					send_targeted(series, full);
				else if (pick < 9)
					send_noise($urandom_range(19, 1));
				else
					send_window($urandom_range(1, 0) ? 4095 : 0, 0);
			end
			settle();
		end

		if (mismatches == 0 && outstanding == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
